// ===== design/sbt_pkg.sv =====
// ----------------------------------------------------------------------------
// sbt_pkg: shared types and constants for the source byte tokenizer
// Item and token structs, scanner mode codes, character codes and the
// byte classification helpers used by the scanner front end.
// ----------------------------------------------------------------------------
`default_nettype none

package sbt_pkg;

  // Width of the running byte position counter (wraps modulo 2^POS_W)
  localparam int POS_W = 32;
  localparam int OFS_W = 32;
  localparam int LEN_W = 32;
  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  // Token queue between scanner and output stage
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Character codes
  localparam logic [7:0] CH_BACKSLASH  = 8'h5C;
  localparam logic [7:0] CH_DQUOTE     = 8'h22;
  localparam logic [7:0] CH_SQUOTE     = 8'h27;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] KIND_TEXT     = 8'h00;

  typedef enum logic [4:0] {
    MODE_IDLE   = 5'b00001,
    MODE_WORD   = 5'b00010,
    MODE_NUMBER = 5'b00100,
    MODE_DQUOTE = 5'b01000,
    MODE_SQUOTE = 5'b10000
  } mode_t;

  typedef struct packed {
    logic [7:0] source_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0]       token_kind;
    logic [OFS_W-1:0] token_offset;
    logic [LEN_W-1:0] token_length;
    logic             last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [7:0]       kind;
    logic [OFS_W-1:0] offset;
    logic [LEN_W-1:0] length;
  } tok_t;

  // One queue entry holds all tokens caused by one byte (one or two)
  typedef struct packed {
    tok_t tok0;
    tok_t tok1;
    logic two;
  } q_entry_t;

  function automatic logic is_letter(input logic [7:0] b);
    return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_word_byte(input logic [7:0] b);
    return is_letter(b) || is_digit(b) || (b == CH_UNDERSCORE);
  endfunction

  // ; , . ( ) { } [ ] > < + - * & | / ^ % : ! = #
  function automatic logic is_punct(input logic [7:0] b);
    logic r;
    case (b)
      8'h3B, 8'h2C, 8'h2E, 8'h28, 8'h29, 8'h7B, 8'h7D, 8'h5B, 8'h5D,
      8'h3E, 8'h3C, 8'h2B, 8'h2D, 8'h2A, 8'h26, 8'h7C, 8'h2F, 8'h5E,
      8'h25, 8'h3A, 8'h21, 8'h3D, 8'h23: begin
        r = 1'b1;
      end
      default: begin
        r = 1'b0;
      end
    endcase
    return r;
  endfunction

  function automatic logic [LEN_W-1:0] sat_inc(input logic [LEN_W-1:0] v);
    return (v == LEN_MAX) ? v : v + LEN_W'(1);
  endfunction

endpackage

`default_nettype wire

// ===== design/sbt_front.sv =====
// ----------------------------------------------------------------------------
// sbt_front: scanner front end
// Holds the scan mode, escape flag, position and pending token; classifies
// each accepted byte and pushes the tokens it causes as one queue entry.
// ----------------------------------------------------------------------------
`default_nettype none

module sbt_front
  import sbt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_push,
  output logic          in_full,
  input  wire in_item_t in_item,
  input  wire logic     q_full,
  output logic          q_push,
  output q_entry_t      q_entry
);

  mode_t            mode_r, mode_nxt;
  logic             esc_r, esc_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [OFS_W-1:0] start_r, start_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;

  logic             accept;
  logic [7:0]       b;
  logic [POS_W-1:0] pos_plus1;
  logic [1:0]       ntok;
  tok_t             tok0, tok1;

  assign in_full   = q_full;
  assign accept    = in_push && !q_full;
  assign b         = in_item.source_byte;
  assign pos_plus1 = pos_r + POS_W'(1);

  always_comb begin
    logic       rescan;
    logic [7:0] quote;
    tok_t       ptok;
    rescan    = 1'b0;
    quote     = CH_DQUOTE;
    ptok      = '0;
    mode_nxt  = mode_r;
    start_nxt = start_r;
    len_nxt   = len_r;
    tok0      = '0;
    tok1      = '0;
    ntok      = 2'd0;

    case (mode_r)
      MODE_WORD, MODE_NUMBER: begin
        if (is_word_byte(b)) begin
          len_nxt = sat_inc(len_r);
        end else begin
          tok0   = '{kind: KIND_TEXT, offset: start_r, length: len_r};
          ntok   = 2'd1;
          rescan = 1'b1;   // delimiter is scanned again as idle
        end
      end
      MODE_DQUOTE, MODE_SQUOTE: begin
        quote = (mode_r == MODE_DQUOTE) ? CH_DQUOTE : CH_SQUOTE;
        if ((b != quote) || esc_r) begin
          len_nxt = sat_inc(len_r);
        end else begin
          tok0     = '{kind: KIND_TEXT, offset: start_r, length: len_r};
          ntok     = 2'd1;
          mode_nxt = MODE_IDLE;
        end
      end
      default: begin
        rescan = 1'b1;
      end
    endcase

    if (rescan) begin
      mode_nxt = MODE_IDLE;
      if (is_punct(b)) begin
        ptok = '{kind: b, offset: OFS_W'(pos_r), length: LEN_W'(1)};
        if (ntok == 2'd0) begin
          tok0 = ptok;
          ntok = 2'd1;
        end else begin
          tok1 = ptok;
          ntok = 2'd2;
        end
      end else if ((b == CH_DQUOTE) || (b == CH_SQUOTE)) begin
        mode_nxt  = (b == CH_DQUOTE) ? MODE_DQUOTE : MODE_SQUOTE;
        start_nxt = OFS_W'(pos_plus1);   // text starts past the quote
        len_nxt   = '0;
      end else if (is_letter(b)) begin
        mode_nxt  = MODE_WORD;
        start_nxt = OFS_W'(pos_r);
        len_nxt   = LEN_W'(1);
      end else if (is_digit(b)) begin
        mode_nxt  = MODE_NUMBER;
        start_nxt = OFS_W'(pos_r);
        len_nxt   = LEN_W'(1);
      end
    end

    esc_nxt = (b == CH_BACKSLASH);
    pos_nxt = pos_plus1;

    // end of text drops anything pending
    if (in_item.end_of_text) begin
      mode_nxt  = MODE_IDLE;
      esc_nxt   = 1'b0;
      pos_nxt   = '0;
      start_nxt = '0;
      len_nxt   = '0;
    end
  end

  assign q_push  = accept && (ntok != 2'd0);
  assign q_entry = '{tok0: tok0, tok1: tok1, two: (ntok == 2'd2)};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      esc_r   <= 1'b0;
      pos_r   <= '0;
      start_r <= '0;
      len_r   <= '0;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      esc_r   <= esc_nxt;
      pos_r   <= pos_nxt;
      start_r <= start_nxt;
      len_r   <= len_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/sbt_queue.sv =====
// ----------------------------------------------------------------------------
// sbt_queue: token queue
// Small register FIFO of per-byte token entries between scanner and output.
// ----------------------------------------------------------------------------
`default_nettype none

module sbt_queue
  import sbt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire q_entry_t push_entry,
  output logic          full,
  input  wire logic     pop,
  output logic          head_valid,
  output q_entry_t      head_entry
);

  q_entry_t          mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full       = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_entry = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/sbt_back.sv =====
// ----------------------------------------------------------------------------
// sbt_back: token output stage
// Splits each queue entry into single tokens, marks the last of each byte,
// and holds the current token in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sbt_back
  import sbt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     head_valid,
  input  wire q_entry_t head_entry,
  output logic          q_pop,
  output logic          out_empty,
  input  wire logic     out_pop,
  output out_item_t     out_item
);

  logic      valid_r;
  logic      sel_r, sel_nxt;
  out_item_t data_r, data_nxt;
  logic      load, take, is_last;
  tok_t      tok;

  assign load    = !valid_r || out_pop;
  assign take    = load && head_valid;
  assign tok     = sel_r ? head_entry.tok1 : head_entry.tok0;
  assign is_last = sel_r || !head_entry.two;
  assign q_pop   = take && is_last;

  always_comb begin
    data_nxt = '{token_kind: tok.kind, token_offset: tok.offset,
                 token_length: tok.length, last_of_run: is_last};
    sel_nxt  = sel_r;
    if (take) begin
      sel_nxt = !is_last;
    end
  end

  assign out_empty = !valid_r;
  assign out_item  = data_r;

  always_ff @(posedge clk) begin
    if (take) begin
      data_r <= data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sel_r   <= 1'b0;
    end else begin
      sel_r <= sel_nxt;
      if (load) begin
        valid_r <= head_valid;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/source_byte_tokenizer_top.sv =====
// ----------------------------------------------------------------------------
// source_byte_tokenizer_top: streaming source byte tokenizer
// Scans one source byte per item and delivers punctuation, word, number and
// string tokens through a queue-style result port.
// ----------------------------------------------------------------------------
// Usage: push one source byte per cycle while in_full is low; set
// end_of_text on the final byte of a text, after which the scanner is back
// at position zero with nothing pending (a word, number or string still open
// at that point gives no token). The scanner takes one byte every cycle
// while in_full is low and pushes the tokens that byte causes into a 4-entry
// queue; a byte that ends a word or number and is itself punctuation gives
// two tokens, and the output stage drains one token per cycle while out_pop
// is high, so sustained rate is one byte per cycle, bounded by the
// one-token-per-cycle output register when tokens are dense. Token offsets
// are the low 32 bits of the byte position; lengths saturate at 2^32-1.
// last_of_run marks the last token caused by a byte.
// ----------------------------------------------------------------------------
`default_nettype none

module source_byte_tokenizer_top
  import sbt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  // byte input, queue style
  input  wire logic     in_push,
  output logic          in_full,
  input  wire in_item_t in_item,
  // token output, queue style
  output logic          out_empty,
  input  wire logic     out_pop,
  output out_item_t     out_item
);

  logic     q_push, q_full, q_pop, q_valid;
  q_entry_t q_in, q_head;

  // Front end: mode tracking and classification, one byte per cycle while the queue has room
  sbt_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_item (in_item),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_entry (q_in)
  );

  // Decoupling queue: absorbs output stalls and two-token bytes
  sbt_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_entry (q_head)
  );

  // Back end: serializes entries into single tokens
  sbt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_valid),
    .head_entry (q_head),
    .q_pop      (q_pop),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_item   (out_item)
  );

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench for source_byte_tokenizer_top
// Streams source bytes into the scanner, predicts every token the bytes should
// give and checks the token stream in order, with random idling on both sides,
// two long output stalls that back the block up, and pauses that let it drain.
// ----------------------------------------------------------------------------

module tb;
  import sbt_pkg::*;

  localparam int TOTAL_BYTES = 900;   // stimulus stops once this many are queued
  localparam int STALL_LIMIT = 2000;  // cycles without any handshake -> give up
  localparam int HOLD_CYCLES = 300;   // long output stall, well past queue depth
  localparam int NUM_MARKS   = 23;
  // the one-byte punctuation tokens
  localparam logic [8*NUM_MARKS-1:0] MARKS = ";,.(){}[]><+-*&|/^%:!=#";

  typedef struct {
    in_item_t item;
    bit       pause;  // hold this item until every owed token has come out
  } feed_t;

  logic      clk     = 1'b0;
  logic      rst_n   = 1'b0;
  logic      in_push = 1'b0;
  logic      in_full;
  in_item_t  in_item = '0;
  logic      out_empty;
  logic      out_pop = 1'b0;
  out_item_t out_item;

  source_byte_tokenizer_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Scanner model state: mode, escape flag, position and the open token
  // --------------------------------------------------------------------------
  mode_t            sc_mode  = MODE_IDLE;
  logic             sc_esc   = 1'b0;
  logic [POS_W-1:0] sc_pos   = '0;
  logic [OFS_W-1:0] sc_start = '0;
  logic [LEN_W-1:0] sc_len   = '0;

  out_item_t   owed_tokens[$];   // tokens the accepted bytes should give, oldest first
  feed_t       byte_queue[$];    // bytes still to be offered
  int unsigned tokens_due   = 0; // driver side: tokens predicted so far
  int unsigned tokens_taken = 0; // monitor side, nonblocking: tokens popped so far
  int unsigned bytes_sent   = 0;
  int unsigned text_ends    = 0;
  int unsigned pair_bytes   = 0; // bytes that gave two tokens
  int unsigned errors       = 0;
  int          eot_odds     = 0; // percent chance of a random end of text

  function automatic bit letter_char(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic bit is_num(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic bit is_mark(input logic [7:0] b);
    for (int i = 0; i < NUM_MARKS; i++) begin
      if (MARKS[8*i +: 8] == b) begin
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void grow_text();
    if (sc_len != '1) begin
      sc_len = sc_len + 1'b1;
    end
  endfunction

  // Idle-mode view of a byte: may open a word, number or string.
  // Returns 1 when the byte is itself a punctuation token.
  function automatic bit open_token(input logic [7:0] b, input logic [POS_W-1:0] at);
    logic [POS_W-1:0] after;
    after   = at + 1'b1;
    sc_mode = MODE_IDLE;
    if (is_mark(b)) begin
      return 1'b1;
    end
    if (b == CH_DQUOTE || b == CH_SQUOTE) begin
      // string text starts past the quote; the quote is not counted
      sc_mode  = (b == CH_DQUOTE) ? MODE_DQUOTE : MODE_SQUOTE;
      sc_start = OFS_W'(after);
      sc_len   = '0;
    end else if (letter_char(b) || is_num(b)) begin
      sc_mode  = letter_char(b) ? MODE_WORD : MODE_NUMBER;
      sc_start = OFS_W'(at);
      sc_len   = LEN_W'(1);
    end
    return 1'b0;
  endfunction

  // Advance the model by one accepted byte and queue the tokens it gives
  task automatic scan_byte(input in_item_t it);
    out_item_t        tok [2];
    int               n;
    bit               mark;
    logic [7:0]       b;
    logic [7:0]       closer;
    logic [POS_W-1:0] at;
    n    = 0;
    mark = 1'b0;
    b    = it.source_byte;
    at   = sc_pos;
    case (sc_mode)
      MODE_WORD, MODE_NUMBER: begin
        if (letter_char(b) || is_num(b) || b == CH_UNDERSCORE) begin
          grow_text();
        end else begin
          // word ends; the delimiter is scanned again as an idle byte
          tok[n] = '{KIND_TEXT, sc_start, sc_len, 1'b0};
          n++;
          mark = open_token(b, at);
        end
      end
      MODE_DQUOTE, MODE_SQUOTE: begin
        closer = (sc_mode == MODE_DQUOTE) ? CH_DQUOTE : CH_SQUOTE;
        if (b != closer || sc_esc) begin
          grow_text();
        end else begin
          tok[n] = '{KIND_TEXT, sc_start, sc_len, 1'b0};
          n++;
          sc_mode = MODE_IDLE;
        end
      end
      default: begin
        mark = open_token(b, at);
      end
    endcase
    if (mark) begin
      tok[n] = '{b, OFS_W'(at), LEN_W'(1), 1'b0};
      n++;
    end
    // any backslash arms the escape, in every mode
    sc_esc = (b == CH_BACKSLASH);
    sc_pos = at + 1'b1;
    if (it.end_of_text) begin
      // an open token is dropped, not flushed
      sc_mode  = MODE_IDLE;
      sc_esc   = 1'b0;
      sc_pos   = '0;
      sc_start = '0;
      sc_len   = '0;
      text_ends++;
    end
    if (n > 0) begin
      tok[n-1].last_of_run = 1'b1;
    end
    if (n == 2) begin
      pair_bytes++;
    end
    for (int i = 0; i < n; i++) begin
      owed_tokens.push_back(tok[i]);
    end
    tokens_due += n;
  endtask

  // Idle length for either side: mostly none or short, a few long, and now and
  // then a calm stretch with no idling at all
  task automatic pick_gap(inout int unsigned calm, output int unsigned gap);
    int unsigned roll;
    roll = $urandom_range(99);
    gap  = 0;
    if (calm > 0) begin
      calm--;
    end else if (roll < 3) begin
      calm = $urandom_range(80, 20);
    end else if (roll < 45) begin
      gap = $urandom_range(3, 1);
    end else if (roll < 53) begin
      gap = $urandom_range(40, 8);
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: offers queued bytes; predicts at the edge where a byte is taken
  // --------------------------------------------------------------------------
  int unsigned feed_gap  = 0;
  int unsigned feed_calm = 0;

  always @(posedge clk) begin : feed_bytes
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (in_push && !in_full) begin
        scan_byte(in_item);
        bytes_sent++;
        pick_gap(feed_calm, feed_gap);
      end
      // a byte refused by a full block stays on the port unchanged
      if (!(in_push && in_full)) begin
        if (feed_gap > 0) begin
          feed_gap--;
          in_push <= 1'b0;
        end else if (byte_queue.size() == 0 ||
                     (byte_queue[0].pause && tokens_taken != tokens_due)) begin
          in_push <= 1'b0;
        end else begin
          in_item <= byte_queue[0].item;
          byte_queue.pop_front();
          in_push <= 1'b1;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: pops tokens and compares each with the oldest owed one
  // --------------------------------------------------------------------------
  int unsigned take_gap  = 0;
  int unsigned take_calm = 0;
  int unsigned hold_left = 0;

  always @(posedge clk) begin : take_tokens
    out_item_t want;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        tokens_taken <= tokens_taken + 1;
        if (owed_tokens.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("tb: unexpected token kind %h offset %0d length %0d last %b",
                     out_item.token_kind, out_item.token_offset,
                     out_item.token_length, out_item.last_of_run);
          end
        end else begin
          want = owed_tokens.pop_front();
          if (out_item.token_kind !== want.token_kind ||
              out_item.token_offset !== want.token_offset ||
              out_item.token_length !== want.token_length ||
              out_item.last_of_run !== want.last_of_run) begin
            errors++;
            if (errors <= 10) begin
              $display("tb: token %0d mismatch: want kind %h offset %0d length %0d last %b",
                       tokens_taken, want.token_kind, want.token_offset,
                       want.token_length, want.last_of_run);
              $display("tb:   got kind %h offset %0d length %0d last %b",
                       out_item.token_kind, out_item.token_offset,
                       out_item.token_length, out_item.last_of_run);
            end
          end
        end
        // twice in the run, stop taking tokens long enough for the block to
        // fill up and push back on its input
        if (tokens_taken + 1 == 40 || tokens_taken + 1 == 350) begin
          hold_left = HOLD_CYCLES;
        end else begin
          pick_gap(take_calm, take_gap);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else if (take_gap > 0) begin
        take_gap--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: too long without either handshake ends the run
  // --------------------------------------------------------------------------
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst_n && ((in_push && !in_full) || (out_pop && !out_empty))) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("tb: timeout, %0d tokens still owed", owed_tokens.size());
    $display("tb: done, errors");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic put_byte(input logic [7:0] b, input bit eot);
    feed_t f;
    f.item.source_byte = b;
    f.item.end_of_text = eot || ($urandom_range(99) < eot_odds);
    // every 300th byte waits for the block to drain first
    f.pause = (byte_queue.size() > 0) && (byte_queue.size() % 300 == 0);
    byte_queue.push_back(f);
  endtask

  task automatic put_text(input string s, input bit eot_at_end);
    for (int i = 0; i < s.len(); i++) begin
      put_byte(s[i], eot_at_end && (i == s.len() - 1));
    end
  endtask

  function automatic logic [7:0] any_word_byte();
    case ($urandom_range(3))
      0:       return "a" + 8'($urandom_range(25));
      1:       return "A" + 8'($urandom_range(25));
      2:       return "0" + 8'($urandom_range(9));
      default: return CH_UNDERSCORE;
    endcase
  endfunction

  initial begin : stimulus
    int unsigned pick;
    int unsigned span;
    int unsigned roll;
    logic [7:0]  quote;

    // directed opening
    put_text("a1_(", 1'b0);        // word ended by punctuation: two tokens, one byte
    put_text("7z ", 1'b0);         // number ended by a skipped byte
    put_text("\"q\\\"\"", 1'b0);   // escaped quote stays inside the string
    put_text("\"\"", 1'b0);        // empty string, length zero
    put_text("\\'x'", 1'b0);       // backslash outside a string: quote still opens
    put_text("'\\\\''", 1'b0);     // backslash after backslash still escapes
    put_byte(8'h00, 1'b0);         // byte extremes, both skipped
    put_byte(8'hFF, 1'b0);
    put_text("ab", 1'b1);          // word open at end of text is dropped
    put_text("'ab", 1'b1);         // so is an open string

    // random part: mostly well-formed fragments, some raw noise,
    // end of text landing anywhere
    eot_odds = 2;
    while (byte_queue.size() < TOTAL_BYTES) begin
      pick = $urandom_range(99);
      if (pick < 28) begin
        if (pick < 9) begin
          put_byte("a" + 8'($urandom_range(25)), 1'b0);
        end else if (pick < 18) begin
          put_byte("A" + 8'($urandom_range(25)), 1'b0);
        end else begin
          put_byte("0" + 8'($urandom_range(9)), 1'b0);
        end
        span = ($urandom_range(19) == 0) ? $urandom_range(60, 30) : $urandom_range(6);
        repeat (span) put_byte(any_word_byte(), 1'b0);
      end else if (pick < 40) begin
        quote = ($urandom_range(1) == 0) ? CH_DQUOTE : CH_SQUOTE;
        put_byte(quote, 1'b0);
        span = $urandom_range(10);
        repeat (span) begin
          roll = $urandom_range(99);
          if (roll < 15) begin
            put_byte(CH_BACKSLASH, 1'b0);
          end else if (roll < 20) begin
            put_byte(CH_DQUOTE, 1'b0);
          end else if (roll < 25) begin
            put_byte(CH_SQUOTE, 1'b0);
          end else begin
            put_byte(8'($urandom_range(8'h7E, 8'h20)), 1'b0);
          end
        end
        put_byte(quote, 1'b0);
      end else if (pick < 62) begin
        put_byte(MARKS[8*$urandom_range(NUM_MARKS-1) +: 8], 1'b0);
      end else if (pick < 72) begin
        put_text(($urandom_range(2) == 0) ? "\n" : " ", 1'b0);
      end else begin
        span = $urandom_range(3, 1);
        repeat (span) put_byte(8'($urandom_range(255)), 1'b0);
      end
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // every byte taken, every owed token seen, then a final wait for strays
    do @(negedge clk); while (byte_queue.size() != 0 || in_push);
    do @(negedge clk); while (owed_tokens.size() != 0);
    repeat (8) @(negedge clk);

    $display("tb: %0d bytes scanned over %0d texts, %0d tokens compared",
             bytes_sent, text_ends, tokens_due);
    $display("tb: %0d bytes gave two tokens, %0d mismatches", pair_bytes, errors);
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/sbt_pkg.sv
design/sbt_front.sv
design/sbt_queue.sv
design/sbt_back.sv
design/source_byte_tokenizer_top.sv
sim/tb.sv
